// ===== rtl/core/pidcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidcc_pkg : shared types and constants of the PID regulator
// Fixed-point format, item layouts, item kinds and register indexes.
// ----------------------------------------------------------------------------
package pidcc_pkg;

	// Q format
	localparam int FRAC_BITS = 16;

	// width of the exact sum of the three products
	localparam int ACC_W = 82;

	// configuration address width (five 32-bit registers)
	localparam int ADDR_W = 5;

	// reset range bound: 10.0
	localparam int LIMIT_RESET_INT = 10;
	localparam logic [30:0] LIMIT_RESET = 31'(LIMIT_RESET_INT << FRAC_BITS);

	// item kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_COMP   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_SETPOINT   = 3'd0;
	localparam logic [2:0] REG_GAIN_P     = 3'd1;
	localparam logic [2:0] REG_GAIN_I     = 3'd2;
	localparam logic [2:0] REG_GAIN_D     = 3'd3;
	localparam logic [2:0] REG_COMP_LIMIT = 3'd4;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] measured;
		logic signed [31:0] comp_delta;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               clamped;
	} out_item_t;

endpackage

// ===== rtl/core/pid_with_compensation_clamp_core.sv =====
// ----------------------------------------------------------------------------
// pid_with_compensation_clamp_core : positional PID regulator, Q16.16
// A sample's result passes the error/sum stage, product stage and sum stage
// and is then loaded into the output register. Throughput: one item per
// cycle unless back-pressure holds the pipeline; the integral and error state
// update in the accept cycle, so back-to-back samples see each other's state.
// Each stage holds its item under back-pressure and bubbles are squeezed out.
// Reset (arst_n low, asynchronous) clears the state and valids and loads the
// register reset values; stage data registers are not reset.
// ----------------------------------------------------------------------------
module pid_with_compensation_clamp_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  pidcc_pkg::in_item_t             sample,
	output logic                            result_valid,
	input  logic                            result_ready,
	output pidcc_pkg::out_item_t            result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pidcc_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import pidcc_pkg::*;

	// configuration
	logic signed [31:0] setpoint_q, gain_p_q, gain_i_q, gain_d_q;
	logic [30:0]        comp_limit_q;
	logic [2:0]         reg_idx;
	logic               cfg_wr;

	// regulator state
	logic signed [47:0] sum_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] tot_q;

	// pipeline
	logic               v_s1, v_s2, v_s3;
	logic signed [31:0] err_s1;
	logic signed [32:0] derr_s1;
	logic signed [47:0] sum_s1;
	logic signed [31:0] tot_s1, tot_s2, tot_s3;
	logic signed [63:0] prod_p_s2;
	logic signed [64:0] prod_d_s2;
	logic signed [56:0] prod_il_s2;
	logic signed [55:0] prod_ih_s2;
	logic signed [ACC_W-1:0] acc_s3;
	logic               out_v_q;
	out_item_t          out_q;

	// flow control
	logic mv_out, adv3, adv2, adv1, accept;

	// stage-1 combinational
	logic signed [32:0] diff;
	logic signed [31:0] err;
	logic signed [32:0] derr;
	logic signed [48:0] sum_ext;
	logic signed [47:0] sum_nxt;
	logic signed [32:0] comp_ext;
	logic signed [31:0] tot_nxt;

	// output-stage combinational
	logic signed [ACC_W-1:0] acc_sh;
	logic               fits;
	logic signed [31:0] drive_raw;
	logic signed [33:0] t_sum, lim34, clip;
	logic signed [31:0] drive_fin;
	logic               clamp_hit;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= '0;
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			comp_limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SETPOINT:   setpoint_q   <= pwdata;
				REG_GAIN_P:     gain_p_q     <= pwdata;
				REG_GAIN_I:     gain_i_q     <= pwdata;
				REG_GAIN_D:     gain_d_q     <= pwdata;
				REG_COMP_LIMIT: comp_limit_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SETPOINT:   prdata = setpoint_q;
			REG_GAIN_P:     prdata = gain_p_q;
			REG_GAIN_I:     prdata = gain_i_q;
			REG_GAIN_D:     prdata = gain_d_q;
			REG_COMP_LIMIT: prdata = {1'b0, comp_limit_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	assign mv_out       = !out_v_q || result_ready;
	assign adv3         = !v_s3 || mv_out;
	assign adv2         = !v_s2 || adv3;
	assign adv1         = !v_s1 || adv2;
	assign sample_ready = adv1;
	assign accept       = sample_valid && sample_ready;

	// ---------------- error, difference, integral ----------------
	always_comb begin
		diff = {setpoint_q[31], setpoint_q} - {sample.measured[31], sample.measured};
		if (diff[32] != diff[31])
			err = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			err = diff[31:0];
		derr    = {err[31], err} - {prev_q[31], prev_q};
		sum_ext = {sum_q[47], sum_q} + {{17{err[31]}}, err};
		if (sum_ext[48] != sum_ext[47])
			sum_nxt = sum_ext[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			sum_nxt = sum_ext[47:0];
		comp_ext = {tot_q[31], tot_q} + {sample.comp_delta[31], sample.comp_delta};
		if (comp_ext[32] != comp_ext[31])
			tot_nxt = comp_ext[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			tot_nxt = comp_ext[31:0];
	end

	// state update at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
			tot_q  <= '0;
		end else if (accept) begin
			case (sample.kind)
				KIND_SAMPLE: begin
					sum_q  <= sum_nxt;
					prev_q <= err;
				end
				KIND_COMP: tot_q <= tot_nxt;
				KIND_CLEAR: begin
					sum_q  <= '0;
					prev_q <= '0;
					tot_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	// ---------------- pipeline valids ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv1)   v_s1    <= accept && (sample.kind == KIND_SAMPLE);
			if (adv2)   v_s2    <= v_s1;
			if (adv3)   v_s3    <= v_s2;
			if (mv_out) out_v_q <= v_s3;
		end
	end

	// stage 1: operands; total is snapshotted for the clamp
	always_ff @(posedge clk) begin
		if (adv1) begin
			err_s1  <= err;
			derr_s1 <= derr;
			sum_s1  <= sum_nxt;
			tot_s1  <= tot_q;
		end
	end

	// stage 2: products, integral product split into two halves
	always_ff @(posedge clk) begin
		if (adv2) begin
			prod_p_s2  <= gain_p_q * err_s1;
			prod_d_s2  <= gain_d_q * derr_s1;
			prod_il_s2 <= gain_i_q * $signed({1'b0, sum_s1[23:0]});
			prod_ih_s2 <= gain_i_q * $signed(sum_s1[47:24]);
			tot_s2     <= tot_s1;
		end
	end

	// stage 3: exact sum
	always_ff @(posedge clk) begin
		if (adv3) begin
			acc_s3 <= $signed({{(ACC_W-64){prod_p_s2[63]}}, prod_p_s2})
				+ $signed({{(ACC_W-65){prod_d_s2[64]}}, prod_d_s2})
				+ $signed({{(ACC_W-57){prod_il_s2[56]}}, prod_il_s2})
				+ $signed({{(ACC_W-80){prod_ih_s2[55]}}, prod_ih_s2, 24'd0});
			tot_s3 <= tot_s2;
		end
	end

	// ---------------- shift, saturate, range clamp ----------------
	always_comb begin
		acc_sh = acc_s3 >>> FRAC_BITS;
		fits   = (&acc_sh[ACC_W-1:31]) || !(|acc_sh[ACC_W-1:31]);
		if (fits)
			drive_raw = acc_sh[31:0];
		else
			drive_raw = acc_s3[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		t_sum     = {{2{drive_raw[31]}}, drive_raw} + {{2{tot_s3[31]}}, tot_s3};
		lim34     = {3'b000, comp_limit_q};
		clamp_hit = 1'b1;
		if (t_sum >= lim34)
			clip = lim34 - {{2{tot_s3[31]}}, tot_s3};
		else if (t_sum <= -lim34)
			clip = -lim34 - {{2{tot_s3[31]}}, tot_s3};
		else begin
			clip      = {{2{drive_raw[31]}}, drive_raw};
			clamp_hit = 1'b0;
		end
		if (clip[33:31] == 3'b000 || clip[33:31] == 3'b111)
			drive_fin = clip[31:0];
		else
			drive_fin = clip[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	end

	// output register
	always_ff @(posedge clk) begin
		if (mv_out) begin
			out_q.drive   <= drive_fin;
			out_q.clamped <= clamp_hit;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	// ---------------- assertions ----------------
	// a clear item leaves all regulator state at zero
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sample.kind == KIND_CLEAR |=> sum_q == '0 && prev_q == '0 && tot_q == '0)
		else $error("state not cleared");

	// an accepted sample enters stage 1
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sample.kind == KIND_SAMPLE |=> v_s1)
		else $error("sample lost at stage 1");

	// an item without a result leaves no bubble marked valid
	a_noresult: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sample.kind != KIND_SAMPLE |=> !v_s1)
		else $error("spurious item in stage 1");

	// a blocked stage-3 item is held, not dropped
	a_hold3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !adv3 |=> v_s3 && $stable(acc_s3))
		else $error("stage 3 item dropped under stall");

	// a waiting result is not overwritten
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !result_ready |=> out_v_q && $stable(out_q))
		else $error("result overwritten while waiting");

endmodule

// ===== tb/sv/tb_pid_with_compensation_clamp_core.sv =====
// ----------------------------------------------------------------------------
// tb_pid_with_compensation_clamp_core : self-checking bench of the PID core
// Sends sample, compensation and clear items through the valid/ready input,
// mirrors the regulator in fixed point to forecast each drive result, and
// compares every result taken from the output channel against the forecast.
// Gains, setpoint and range bound are rewritten over the APB port between
// phases, with random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_pid_with_compensation_clamp_core;
	timeunit 1ns;
	timeprecision 1ps;

	import pidcc_pkg::*;

	// codes the package leaves out
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [2:0] REG_SPARE  = 3'd5;

	localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint S32_MIN = -64'sh0000_0000_8000_0000;
	localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint S48_MIN = -S48_MAX - 1;
	localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] W_MIN = 32'h8000_0000;

	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int FULL_ERR_SAMPLES = 8;
	localparam int PHASE_ITEMS   = 160;
	localparam int NUM_PHASES    = 5;
	localparam int CYCLE_LIMIT   = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	in_item_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_item_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pid_with_compensation_clamp_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// register mirror
	logic signed [31:0] cfg_setpoint = '0;
	logic signed [31:0] cfg_gain_p = '0;
	logic signed [31:0] cfg_gain_i = '0;
	logic signed [31:0] cfg_gain_d = '0;
	logic [30:0] cfg_limit = LIMIT_RESET;

	// regulator state mirror
	logic signed [47:0] integ_sum = '0;
	logic signed [31:0] last_error = '0;
	logic signed [31:0] comp_total = '0;

	in_item_t item_backlog[$];
	out_item_t drive_forecast[$];
	int drive_errors = 0;
	int unsigned cycle_count = 0;

	// idling controls, set per phase
	bit send_idle_en = 1'b0;
	bit recv_idle_en = 1'b0;
	int hold_req = 0;

	function automatic longint sat32(input longint v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return v;
	endfunction

	function automatic logic signed [ACC_W-1:0] widen(input longint v);
		return v;
	endfunction

	// advance the regulator mirror by one item, forecast the drive of a sample
	function automatic void predict_drive(input in_item_t it);
		longint err, derr, sum, drv, lim, t;
		logic signed [ACC_W-1:0] acc, shifted;
		out_item_t res;
		case (it.kind)
			KIND_COMP: begin
				comp_total = 32'(sat32(longint'(comp_total) + longint'(it.comp_delta)));
			end
			KIND_CLEAR: begin
				integ_sum = '0;
				last_error = '0;
				comp_total = '0;
			end
			KIND_SAMPLE: begin
				err = sat32(longint'(cfg_setpoint) - longint'(it.measured));
				derr = err - longint'(last_error);
				sum = longint'(integ_sum) + err;
				if (sum > S48_MAX)
					sum = S48_MAX;
				else if (sum < S48_MIN)
					sum = S48_MIN;
				integ_sum = 48'(sum);
				last_error = 32'(err);
				// exact sum of products, floor shift, saturate
				acc = widen(cfg_gain_p) * widen(err) + widen(cfg_gain_i) * widen(sum)
					+ widen(cfg_gain_d) * widen(derr);
				shifted = acc >>> FRAC_BITS;
				if (shifted > widen(S32_MAX))
					drv = S32_MAX;
				else if (shifted < widen(S32_MIN))
					drv = S32_MIN;
				else
					drv = longint'(shifted);
				// range clamp on drive plus compensation, positive rule first
				lim = longint'(cfg_limit);
				t = drv + longint'(comp_total);
				res.clamped = 1'b0;
				if (t >= lim) begin
					drv = sat32(lim - longint'(comp_total));
					res.clamped = 1'b1;
				end else if (t <= -lim) begin
					drv = sat32(-lim - longint'(comp_total));
					res.clamped = 1'b1;
				end
				res.drive = 32'(drv);
				drive_forecast = {drive_forecast, res};
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void flag_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		drive_errors++;
		if (drive_errors <= 10)
			$display("mismatch in %s: expected %h, got %h", what, want, got);
	endfunction

	// input driver: sends the backlog, random gap bursts after items
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			send_gap <= 0;
		end else begin
			if (sample_valid && sample_ready)
				predict_drive(sample);
			if (!sample_valid || sample_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					sample_valid <= 1'b0;
				end else if (item_backlog.size() != 0) begin
					sample <= item_backlog.pop_front();
					sample_valid <= 1'b1;
					if (send_idle_en && $urandom_range(0, 7) == 0)
						send_gap <= $urandom_range(1, 19);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks results, random stalls and one long hold-off
	int recv_gap = 0;
	int hold_left = 0;
	int hold_seen = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_gap <= 0;
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (drive_forecast.size() == 0) begin
					flag_mismatch("result with none pending, drive", '0, result.drive);
				end else begin
					if (result.drive !== drive_forecast[0].drive)
						flag_mismatch("drive", drive_forecast[0].drive, result.drive);
					if (result.clamped !== drive_forecast[0].clamped)
						flag_mismatch("clamped", 32'(drive_forecast[0].clamped),
							32'(result.clamped));
					void'(drive_forecast.pop_front());
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
				result_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				result_ready <= 1'b0;
			end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(0, 18);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic void queue_item(input logic [1:0] kind, input logic [31:0] meas,
		input logic [31:0] delta);
		in_item_t it;
		it.kind = kind;
		it.measured = meas;
		it.comp_delta = delta;
		item_backlog = {item_backlog, it};
	endfunction

	// APB write: setup cycle then access cycle
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SETPOINT:   cfg_setpoint = value;
			REG_GAIN_P:     cfg_gain_p = value;
			REG_GAIN_I:     cfg_gain_i = value;
			REG_GAIN_D:     cfg_gain_d = value;
			REG_COMP_LIMIT: cfg_limit = value[30:0];
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [31:0] sp, input logic [31:0] gp,
		input logic [31:0] gi, input logic [31:0] gd, input logic [31:0] lim);
		write_reg(REG_SETPOINT, sp);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_COMP_LIMIT, lim);
		@(negedge clk);
	endtask

	// wait until every item is sent and every result is back, then let it settle
	task automatic drain();
		do
			@(negedge clk);
		while (item_backlog.size() != 0 || sample_valid || drive_forecast.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return W_MAX;
			1: return W_MIN;
			2: return $urandom();
			3: return '0;
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	initial begin
		int sent;
		int r;
		logic [31:0] lim;
		logic [31:0] sp;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero gains, compensation overflow, clear, spare kind
		queue_item(KIND_SAMPLE, '0, $urandom());
		queue_item(KIND_COMP, $urandom(), W_MAX);
		queue_item(KIND_COMP, $urandom(), W_MAX);
		queue_item(KIND_SAMPLE, W_MIN, $urandom());
		queue_item(KIND_SPARE, $urandom(), $urandom());
		queue_item(KIND_CLEAR, $urandom(), $urandom());
		queue_item(KIND_SAMPLE, 32'h0001_2345, $urandom());
		drain();

		// extreme gains: error and drive overflow, negative compensation overflow
		configure(W_MAX, W_MAX, W_MIN, W_MAX, W_MAX);
		write_reg(REG_SPARE, $urandom());
		queue_item(KIND_SAMPLE, W_MIN, $urandom());
		queue_item(KIND_SAMPLE, W_MAX, $urandom());
		queue_item(KIND_SAMPLE, W_MIN, $urandom());
		queue_item(KIND_COMP, $urandom(), W_MIN);
		queue_item(KIND_COMP, $urandom(), W_MIN);
		queue_item(KIND_COMP, $urandom(), W_MIN);
		queue_item(KIND_SAMPLE, '0, $urandom());
		drain();

		// zero range bound (bit 31 of the write is dropped)
		configure(W_MIN, 32'h0001_0000, 32'h0000_0001, W_MIN, W_MIN);
		queue_item(KIND_SAMPLE, W_MAX, $urandom());
		queue_item(KIND_SAMPLE, '0, $urandom());
		queue_item(KIND_CLEAR, $urandom(), $urandom());
		queue_item(KIND_SAMPLE, W_MIN, $urandom());
		queue_item(KIND_COMP, $urandom(), W_MIN);
		queue_item(KIND_SAMPLE, W_MIN, $urandom());
		drain();

		// integral growth at full-scale error, both signs, no idling
		configure(W_MAX, '0, 32'h0000_0001, '0, W_MAX);
		queue_item(KIND_CLEAR, $urandom(), $urandom());
		for (int i = 0; i < FULL_ERR_SAMPLES; i++)
			queue_item(KIND_SAMPLE, W_MIN, $urandom());
		drain();
		write_reg(REG_SETPOINT, W_MIN);
		queue_item(KIND_CLEAR, $urandom(), $urandom());
		for (int i = 0; i < FULL_ERR_SAMPLES; i++)
			queue_item(KIND_SAMPLE, W_MAX, $urandom());
		drain();

		// random phases
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: lim = '0;
				1: lim = W_MAX;
				default: lim = ($urandom_range(0, 1) != 0) ? $urandom()
					: $urandom_range(0, 32'h0100_0000);
			endcase
			sp = ($urandom_range(0, 1) != 0) ? $urandom()
				: $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
			configure(sp, pick_gain(), pick_gain(), pick_gain(), lim);
			send_idle_en = (p == 0 || p == 1 || p == 3);
			recv_idle_en = (p == 0 || p == 2 || p == 3);
			if (p == 2)
				hold_req++;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					queue_item(KIND_COMP, $urandom(), ($urandom_range(0, 4) < 3)
						? $urandom_range(0, 32'h0020_0000) - 32'h0010_0000 : $urandom());
					sent++;
				end else if (r < 20) begin
					queue_item(KIND_CLEAR, $urandom(), $urandom());
					sent++;
				end else if (r < 23) begin
					queue_item(KIND_SPARE, $urandom(), $urandom());
				end else begin
					queue_item(KIND_SAMPLE, ($urandom_range(0, 1) != 0) ? $urandom()
						: cfg_setpoint + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
						$urandom());
					sent++;
				end
				// sender waits for all results halfway through one phase
				if (p == 1 && sent == PHASE_ITEMS / 2)
					drain();
			end
			drain();
		end

		if (drive_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
